@@ rtl/box_filter_mip_chain_generator_core_defines.svh @@
// Assertion macros for the mip chain generator.
`ifndef BOX_FILTER_MIP_CHAIN_GENERATOR_CORE_DEFINES_SVH
`define BOX_FILTER_MIP_CHAIN_GENERATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BFM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BFM_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BFM_ASSERT(label, clk, rst, prop, msg)
`define BFM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ rtl/bfm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared types and constants of the mip chain generator.
// ----------------------------------------------------------------------------
package bfm_pkg;
  localparam int MAX_DIM      = 4096;
  localparam int MAX_LEVELS   = 13;
  localparam int MAX_CHANNELS = 4;
  localparam int AW   = $clog2(MAX_DIM);
  localparam int LW   = 4;
  localparam int PW   = 9;
  localparam int QW   = 10;

  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_LEVELS   = 2'd2;
  localparam logic [1:0] REG_CHANNELS = 2'd3;

  typedef struct packed {
    logic [7:0] chan3;
    logic [7:0] chan2;
    logic [7:0] chan1;
    logic [7:0] chan0;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  level;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  out0;
    logic [7:0]  out1;
    logic [7:0]  out2;
    logic [7:0]  out3;
    logic        run_last;
    logic        image_done;
  } out_item_t;

  typedef struct packed {
    logic [3:0][PW-1:0] ch;
  } pair_t;

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_READ, S_EMIT} state_t;

  typedef struct packed {
    logic            hor_self;
    logic            ver_self;
    logic            pend_odd;
    logic            row_odd;
  } lane_ctl_t;
endpackage

@@ rtl/bfm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfm_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module bfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/bfm_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfm_lane
// One channel of the 2x2 box filter: pair sum and quad average.
// ----------------------------------------------------------------------------
module bfm_lane (
  input  logic                  val_en,
  input  logic [7:0]            val,
  input  logic [bfm_pkg::PW-1:0] pend,
  input  logic [bfm_pkg::PW-1:0] row,
  input  bfm_pkg::lane_ctl_t    ctl,
  output logic [bfm_pkg::PW-1:0] pair,
  output logic [7:0]            avg
);
  import bfm_pkg::*;
  logic [7:0]    v;
  logic [QW-1:0] quad;
  logic [QW:0]   rnd;

  always_comb begin
    v    = val_en ? val : 8'd0;
    pair = ctl.hor_self ? {v, 1'b0} : (pend + {1'b0, v});
    quad = ctl.ver_self ? {pair, 1'b0} : ({1'b0, row} + {1'b0, pair});
    rnd  = {1'b0, quad} + (QW+1)'(2);
    avg  = rnd[9:2];
  end
endmodule

@@ rtl/box_filter_mip_chain_generator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_mip_chain_generator_core
// Each accepted texel is echoed at level 0 and folded into the coarser levels.
// A texel is taken in the idle state; each result it causes then takes a level
// step and a result transaction, with a row store read between them at an
// odd row, as the single row store has a registered read. Output back-pressure
// stalls the result transaction. Four channel lanes compute side by side and
// a result register holds the result. Results leave through an output
// register, so the next texel is taken while the last result waits.
// ----------------------------------------------------------------------------
`include "box_filter_mip_chain_generator_core_defines.svh"
module box_filter_mip_chain_generator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bfm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bfm_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  import bfm_pkg::*;

  logic [12:0] image_width, image_height;
  logic [3:0]  level_count;
  logic [2:0]  channel_count;
  logic [11:0] col_count [MAX_LEVELS];
  logic [11:0] row_count [MAX_LEVELS];
  pair_t       pending_pair [MAX_LEVELS];
  state_t      state, state_next;
  logic [3:0]  lvl;
  logic [AW:0] off;
  logic [3:0][7:0] val;
  logic        final_t, last_flag;
  logic        cfg_wr;
  out_item_t   res_hold;
  logic [3:0][7:0] avg_q;
  logic        idx_ok_q;

  logic [12:0] wd0, ht0, wd_l, ht_l, wd_n, ht_n;
  logic [3:0]  lv;
  logic [2:0]  nch;
  logic [11:0] cx, cy;
  logic [AW:0] idx;
  logic        idx_ok, go_on, is_emit_last;
  lane_ctl_t   ctl;
  pair_t       pair, row_rd;
  logic [3:0][7:0] avg;
  logic        ram_we;
  logic [PW*4-1:0] ram_rdata;
  logic        is_store;

  assign cfg_ready = (state == S_IDLE);
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    wd0 = (image_width == 13'd0) ? 13'd1 : (image_width > 13'd4096 ? 13'd4096 : image_width);
    ht0 = (image_height == 13'd0) ? 13'd1 :
          (image_height > 13'd4096 ? 13'd4096 : image_height);
    lv  = (level_count == 4'd0) ? 4'd1 : (level_count > 4'd13 ? 4'd13 : level_count);
    nch = (channel_count == 3'd0) ? 3'd1 : (channel_count > 3'd4 ? 3'd4 : channel_count);
    wd_l = wd0 >> lvl;
    ht_l = ht0 >> lvl;
    if (wd_l == 13'd0) wd_l = 13'd1;
    if (ht_l == 13'd0) ht_l = 13'd1;
    wd_n = (wd_l > 13'd1) ? (wd_l >> 1) : 13'd1;
    ht_n = (ht_l > 13'd1) ? (ht_l >> 1) : 13'd1;
    cx = col_count[lvl];
    cy = row_count[lvl];
    ctl.hor_self = (wd_l == 13'd1);
    ctl.ver_self = (ht_l == 13'd1);
    ctl.pend_odd = cx[0];
    ctl.row_odd  = cy[0];
    idx    = off + (AW+1)'(ctl.hor_self ? 12'd0 : (cx >> 1));
    idx_ok = (idx < (AW+1)'(MAX_DIM));
    go_on  = 1'b0;
    is_store = 1'b0;
    if (lvl + 4'd1 < lv) begin
      if (ctl.hor_self || ({1'b0, cx} < {wd_n[11:0], 1'b0})) begin
        if (ctl.hor_self || cx[0]) begin
          if (ctl.ver_self) go_on = 1'b1;
          else if ({1'b0, cy} < {ht_n[11:0], 1'b0}) begin
            if (cy[0]) go_on = 1'b1;
            else is_store = 1'b1;
          end
        end
      end
    end
    is_emit_last = !go_on;
  end

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    assign row_rd.ch[g] = idx_ok_q ? ram_rdata[g*PW +: PW] : '0;
    bfm_lane u_lane (
      .val_en (1'b1),
      .val    (val[g]),
      .pend   (pending_pair[lvl].ch[g]),
      .row    (row_rd.ch[g]),
      .ctl    (ctl),
      .pair   (pair.ch[g]),
      .avg    (avg[g])
    );
  end

  assign ram_we = (state == S_CALC) && is_store && idx_ok && !ctl.ver_self;

  bfm_ram #(.WIDTH(PW*4), .DEPTH(MAX_DIM)) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx[AW-1:0]),
    .wdata (pair),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid && in_ready) state_next = S_CALC;
      S_CALC: state_next = (go_on && !ctl.ver_self) ? S_READ : S_EMIT;
      S_READ: state_next = S_EMIT;
      S_EMIT: begin
        if (!out_valid || out_ready) state_next = last_flag ? S_IDLE : S_CALC;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      image_width <= 13'd1;
      image_height <= 13'd1;
      level_count <= 4'd1;
      channel_count <= 3'd4;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        col_count[i] <= '0;
        row_count[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_EMIT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_WIDTH:    image_width <= cfg_data;
          REG_HEIGHT:   image_height <= cfg_data;
          REG_LEVELS:   level_count <= cfg_data[3:0];
          REG_CHANNELS: channel_count <= cfg_data[2:0];
          default: ;
        endcase
        for (int i = 0; i < MAX_LEVELS; i++) begin
          col_count[i] <= '0;
          row_count[i] <= '0;
        end
      end
      if (state == S_IDLE && in_valid && in_ready) begin
        lvl <= '0;
        off <= '0;
        val[0] <= in_data.chan0;
        val[1] <= (nch > 3'd1) ? in_data.chan1 : 8'd0;
        val[2] <= (nch > 3'd2) ? in_data.chan2 : 8'd0;
        val[3] <= (nch > 3'd3) ? in_data.chan3 : 8'd0;
        final_t <= ({1'b0, col_count[0]} + 13'd1 >= wd0) &&
                   ({1'b0, row_count[0]} + 13'd1 >= ht0);
      end
      if (state == S_CALC || state == S_READ) begin
        avg_q <= avg;
      end
      if (state == S_CALC) begin
        last_flag <= is_emit_last;
        idx_ok_q <= idx_ok;
        res_hold.level <= lvl;
        res_hold.pos_x <= cx;
        res_hold.pos_y <= cy;
        res_hold.out0 <= val[0];
        res_hold.out1 <= val[1];
        res_hold.out2 <= val[2];
        res_hold.out3 <= val[3];
        res_hold.run_last <= is_emit_last;
        res_hold.image_done <= is_emit_last && final_t;
        if ({1'b0, cx} + 13'd1 >= wd_l) begin
          col_count[lvl] <= '0;
          row_count[lvl] <= ({1'b0, cy} + 13'd1 >= ht_l) ? 12'd0 : cy + 12'd1;
        end else begin
          col_count[lvl] <= cx + 12'd1;
        end
        if (lvl + 4'd1 < lv && !ctl.hor_self && !cx[0] &&
            ({1'b0, cx} < {wd_n[11:0], 1'b0})) begin
          for (int g = 0; g < MAX_CHANNELS; g++) pending_pair[lvl].ch[g] <= {1'b0, val[g]};
        end
      end
      if (state == S_EMIT && (!out_valid || out_ready)) begin
        out_data <= res_hold;
      end
      if (state == S_EMIT && (!out_valid || out_ready) && !last_flag) begin
        val <= avg_q;
        off <= off + (AW+1)'(wd_n);
        lvl <= lvl + 4'd1;
      end
    end
  end

  `BFM_ASSERT(a_in_idle, clk, rst, (in_valid && in_ready) |-> (state == S_IDLE),
              "texel taken while busy")
  `BFM_ASSERT(a_lvl_rng, clk, rst, (state != S_IDLE) |-> (lvl < lv),
              "level beyond level count")
  `BFM_ASSERT(a_cfg_idle, clk, rst, cfg_wr |-> (state == S_IDLE),
              "configuration written while busy")
  `BFM_ASSERT(a_emit, clk, rst, (state == S_EMIT && !out_valid) |=> out_valid,
              "result not presented")
endmodule
